[hw/rtl/rmq_pkg.sv]
package rmq_pkg;

    // Which quaternion component takes the half root.
    localparam logic [1:0] SEL_X     = 2'd0;
    localparam logic [1:0] SEL_Y     = 2'd1;
    localparam logic [1:0] SEL_Z     = 2'd2;
    localparam logic [1:0] SEL_TRACE = 2'd3;

    // Control data that rides along the pipeline next to the arithmetic.
    typedef struct packed {
        logic [1:0] sel;
        logic [2:0] neg;
    } meta_t;

endpackage

[hw/rtl/rmq_delay.sv]
module rmq_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    // Shift line that advances only when the pipeline moves.
    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int t = 1; t < DEPTH; t++) begin
                tap_reg[t] <= tap_reg[t-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

[hw/rtl/rmq_front.sv]
module rmq_front #(
    parameter int W = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [9*W-1:0]       mat,
    output logic [W:0]           rad_reg,
    output logic [2:0][W:0]      mag_reg,
    output rmq_pkg::meta_t       meta_reg
);

    localparam int XW = W + 3;

    logic signed [XW-1:0] m [0:8];
    logic signed [XW-1:0] one;
    logic signed [XW-1:0] tr;
    logic signed [XW-1:0] rad;
    logic signed [XW-1:0] dii;
    logic signed [XW-1:0] n [0:2];
    logic [1:0]           idx;
    logic [1:0]           sel;
    logic [W:0]           rad_next;
    logic [2:0][W:0]      mag_next;
    logic [2:0]           neg_next;

    assign one = XW'(1) <<< (W - 2);

    // Sign-extend every element to a width where no sum can overflow.
    always_comb begin
        for (int e = 0; e < 9; e++) begin
            m[e] = XW'($signed(mat[e*W +: W]));
        end
    end

    // Trace test, pivot choice and the three numerators of each case.
    always_comb begin
        tr  = m[0] + m[4] + m[8];
        idx = 2'd0;
        if (m[4] > m[0]) begin
            idx = 2'd1;
        end
        if (m[8] > ((idx == 2'd1) ? m[4] : m[0])) begin
            idx = 2'd2;
        end
        if (tr > 0) begin
            sel  = rmq_pkg::SEL_TRACE;
            rad  = tr + one;
            n[0] = m[5] - m[7];
            n[1] = m[6] - m[2];
            n[2] = m[1] - m[3];
        end else begin
            case (idx)
                2'd0: begin
                    sel  = rmq_pkg::SEL_X;
                    dii  = m[0] - (m[4] + m[8]);
                    n[0] = m[5] - m[7];
                    n[1] = m[1] + m[3];
                    n[2] = m[2] + m[6];
                end
                2'd1: begin
                    sel  = rmq_pkg::SEL_Y;
                    dii  = m[4] - (m[8] + m[0]);
                    n[0] = m[6] - m[2];
                    n[1] = m[5] + m[7];
                    n[2] = m[3] + m[1];
                end
                default: begin
                    sel  = rmq_pkg::SEL_Z;
                    dii  = m[8] - (m[0] + m[4]);
                    n[0] = m[1] - m[3];
                    n[1] = m[6] + m[2];
                    n[2] = m[7] + m[5];
                end
            endcase
            rad = dii + one;
        end
        if (tr > 0) begin
            dii = '0;
        end
        rad_next = (rad <= 0) ? '0 : rad[W:0];
        for (int l = 0; l < 3; l++) begin
            neg_next[l] = n[l][XW-1];
            mag_next[l] = neg_next[l] ? (W+1)'(0) - n[l][W:0] : n[l][W:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg      <= rad_next;
            mag_reg      <= mag_next;
            meta_reg.sel <= sel;
            meta_reg.neg <= neg_next;
        end
    end

endmodule

[hw/rtl/rmq_sqrt.sv]
module rmq_sqrt #(
    parameter int W = 16
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W:0]   rad,
    output logic [W-1:0] root
);

    logic [W+1:0]   rem_w  [0:W];
    logic [W-1:0]   root_w [0:W];
    logic [2*W-1:0] val_w  [0:W];

    // The radicand is scaled by the fraction bits before the root.
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign val_w[0]  = {1'b0, rad, {(W-2){1'b0}}};

    // One result bit per stage, two radicand bits consumed per stage.
    for (genvar g = 0; g < W; g++) begin : g_stage
        logic [W+3:0]   cur;
        logic [W+3:0]   sub;
        logic [W+1:0]   rem_reg;
        logic [W-1:0]   root_reg;
        logic [2*W-1:0] val_reg;

        assign cur = {rem_w[g], val_w[g][2*W-1 -: 2]};
        assign sub = {2'b00, root_w[g], 2'b01};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (cur >= sub) begin
                    rem_reg  <= (W+2)'(cur - sub);
                    root_reg <= {root_w[g][W-2:0], 1'b1};
                end else begin
                    rem_reg  <= cur[W+1:0];
                    root_reg <= {root_w[g][W-2:0], 1'b0};
                end
                val_reg <= {val_w[g][2*W-3:0], 2'b00};
            end
        end

        assign rem_w[g+1]  = rem_reg;
        assign root_w[g+1] = root_reg;
        assign val_w[g+1]  = val_reg;
    end

    assign root = root_w[W];

endmodule

[hw/rtl/rmq_div.sv]
module rmq_div #(
    parameter int W = 16
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [W:0]     mag,
    input  logic [W-1:0]   root,
    output logic [2*W-2:0] quo
);

    localparam int NW = 2 * W - 1;

    logic [W:0]    rem_w [0:NW];
    logic [W:0]    den_w [0:NW];
    logic [NW-1:0] num_w [0:NW];
    logic [NW-1:0] quo_w [0:NW];
    logic [NW-1:0] num_reg;
    logic [W:0]    den_reg;

    // Prepare the dividend with the rounding term and the doubled divisor.
    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= {mag, {(W-2){1'b0}}} + NW'(root);
            den_reg <= {root, 1'b0};
        end
    end

    assign rem_w[0] = '0;
    assign den_w[0] = den_reg;
    assign num_w[0] = num_reg;
    assign quo_w[0] = '0;

    // Restoring division, one quotient bit per stage.
    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [W+1:0]  cur;
        logic [W:0]    rem_reg;
        logic [W:0]    den_reg_s;
        logic [NW-1:0] num_reg_s;
        logic [NW-1:0] quo_reg;

        assign cur = {rem_w[g], num_w[g][NW-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (cur >= {1'b0, den_w[g]}) begin
                    rem_reg <= (W+1)'(cur - {1'b0, den_w[g]});
                    quo_reg <= {quo_w[g][NW-2:0], 1'b1};
                end else begin
                    rem_reg <= cur[W:0];
                    quo_reg <= {quo_w[g][NW-2:0], 1'b0};
                end
                den_reg_s <= den_w[g];
                num_reg_s <= {num_w[g][NW-2:0], 1'b0};
            end
        end

        assign rem_w[g+1] = rem_reg;
        assign den_w[g+1] = den_reg_s;
        assign num_w[g+1] = num_reg_s;
        assign quo_w[g+1] = quo_reg;
    end

    assign quo = quo_w[NW];

endmodule

[hw/rtl/rotation_matrix_to_quaternion_unit.sv]
// Channel  | Direction | Payload (from the lowest bit up)
// s_axis   | in        | m00 m01 m02 m10 m11 m12 m20 m21 m22, DATA_WIDTH bits each
// m_axis   | out       | qw qx qy qz, DATA_WIDTH bits each
//
// One matrix is taken every cycle unless a held result stalls the output.
// The latency is set by the bit-per-stage square root (DATA_WIDTH stages) followed
// by the bit-per-stage divider (2*DATA_WIDTH-1 stages plus one preparation stage).
// Reset clears only the valid bits of the pipeline.
// A stall on the output freezes every stage at once, so nothing is lost or repeated.
module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // qw, qx, qy, qz
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata
);

    localparam int W    = DATA_WIDTH;
    localparam int NW   = 2 * W - 1;
    localparam int LAT  = 3 * W + 2;
    localparam int OUTW = ((4 * W + 7) / 8) * 8;

    logic                     en;
    logic [LAT-1:0]           vld_reg;
    logic [LAT-1:0]           vld_next;
    logic [W:0]               rad;
    logic [2:0][W:0]          mag;
    logic [2:0][W:0]          mag_d;
    rmq_pkg::meta_t           meta;
    rmq_pkg::meta_t           meta_d;
    logic [W-1:0]             root;
    logic [W-1:0]             root_d;
    logic [2:0][NW-1:0]       quo;
    logic [W-1:0]             half;
    logic [3:0][W-1:0]        comp;
    logic [W-1:0]             lane [0:2];
    logic [OUTW-1:0]          tdata_next;
    logic [OUTW-1:0]          tdata_reg;

    // The whole pipeline advances unless a finished result is held back.
    assign en            = m_axis_tready | ~m_axis_tvalid;
    assign s_axis_tready = en;

    // Valid bits travel with the data through every stage.
    assign vld_next = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];

    rmq_front #(.W(W)) u_front (
        .aclk     (aclk),
        .en       (en),
        .mat      (s_axis_tdata[9*W-1:0]),
        .rad_reg  (rad),
        .mag_reg  (mag),
        .meta_reg (meta)
    );

    rmq_sqrt #(.W(W)) u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (rad),
        .root (root)
    );

    // Numerators wait for the root.
    rmq_delay #(.WIDTH(3*(W+1)), .DEPTH(W)) u_mag_dly (
        .aclk (aclk),
        .en   (en),
        .din  (mag),
        .dout (mag_d)
    );

    for (genvar l = 0; l < 3; l++) begin : g_div
        rmq_div #(.W(W)) u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (mag_d[l]),
            .root (root),
            .quo  (quo[l])
        );
    end

    // The root and the control data wait for the quotients.
    rmq_delay #(.WIDTH(W), .DEPTH(NW+1)) u_root_dly (
        .aclk (aclk),
        .en   (en),
        .din  (root),
        .dout (root_d)
    );

    rmq_delay #(.WIDTH($bits(rmq_pkg::meta_t)), .DEPTH(W+NW+1)) u_meta_dly (
        .aclk (aclk),
        .en   (en),
        .din  (meta),
        .dout (meta_d)
    );

    // Half root, signed saturation of each quotient and component placement.
    always_comb begin
        logic [W:0] hsum;
        hsum = {1'b0, root_d} + (W+1)'(1);
        half = (hsum[W:1] > {1'b0, {(W-1){1'b1}}}) ? {1'b0, {(W-1){1'b1}}} : hsum[W:1];
        for (int l = 0; l < 3; l++) begin
            if (meta_d.neg[l]) begin
                if (quo[l] > NW'({1'b1, {(W-1){1'b0}}})) begin
                    lane[l] = {1'b1, {(W-1){1'b0}}};
                end else begin
                    lane[l] = W'(0) - quo[l][W-1:0];
                end
            end else begin
                if (quo[l] > NW'({1'b0, {(W-1){1'b1}}})) begin
                    lane[l] = {1'b0, {(W-1){1'b1}}};
                end else begin
                    lane[l] = quo[l][W-1:0];
                end
            end
        end
        case (meta_d.sel)
            rmq_pkg::SEL_X: begin
                comp = {lane[2], lane[1], half, lane[0]};
            end
            rmq_pkg::SEL_Y: begin
                comp = {lane[1], half, lane[2], lane[0]};
            end
            rmq_pkg::SEL_Z: begin
                comp = {half, lane[2], lane[1], lane[0]};
            end
            default: begin
                comp = {lane[2], lane[1], lane[0], half};
            end
        endcase
        if (root_d == '0) begin
            comp = '0;
        end
        tdata_next = OUTW'(comp);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (en) begin
            tdata_reg <= tdata_next;
        end
    end

    assign m_axis_tdata = tdata_reg;

endmodule

[hw/rtl/rmq_checker.sv]
module rmq_checker #(
    parameter int OUTW = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_axis_tready,
    input  logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  logic [OUTW-1:0] m_axis_tdata
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("held result changed");

    // A consumer that is ready never blocks the input.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output ready");

    // A held result stalls the input.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken during output stall");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(.OUTW(OUTW)) u_rmq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
